### rtl/core/riscv_operand_text_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Operand text parser assertion macros
// Shared property wrappers for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef RISCV_OPERAND_TEXT_PARSER_CORE_DEFINES_SVH
`define RISCV_OPERAND_TEXT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROTP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ROTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rotp_pkg.sv
// ----------------------------------------------------------------------------
// Operand text parser package
// Types and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package rotp_pkg;

    // Operand format codes
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;

    // Characters with a meaning to the parser
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [2:0] NAME_MAX = 3'd4;
    localparam logic [2:0] NAME_SAT = 3'd5;

    typedef enum logic [1:0] {
        IMM_START,
        IMM_SIGNED,
        IMM_DIGITS
    } imm_stage_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic [2:0] operand_format;
        logic       last_char;
    } rotp_item_t;

    typedef struct packed {
        logic [4:0]        dest_reg;
        logic [4:0]        src1_reg;
        logic [4:0]        src2_reg;
        logic signed [15:0] immediate;
        logic              parse_error;
    } rotp_result_t;

endpackage

### rtl/core/rotp_reg_decode.sv
// ----------------------------------------------------------------------------
// Register name decoder
// Maps a buffered name of up to four characters to a register number.
// ----------------------------------------------------------------------------
module rotp_reg_decode
    import rotp_pkg::*;
(
    input  logic [31:0] name_chars,
    input  logic [2:0]  name_length,
    output logic        name_hit,
    output logic [4:0]  name_num
);

    logic [7:0] b0, b1, b2, b3;
    logic [3:0] d1;
    logic [5:0] x_val;
    logic       b1_digit, b2_digit;

    assign b0 = name_chars[7:0];
    assign b1 = name_chars[15:8];
    assign b2 = name_chars[23:16];
    assign b3 = name_chars[31:24];
    assign d1 = b1[3:0];
    assign b1_digit = (b1 >= CH_ZERO) && (b1 <= CH_NINE);
    assign b2_digit = (b2 >= CH_ZERO) && (b2 <= CH_NINE);
    // tens * 10 + units for two-digit x names
    assign x_val = {1'b0, b1[1:0], 3'b000} + {3'b000, b1[1:0], 1'b0} + {2'b00, b2[3:0]};

    always_comb begin
        name_hit = 1'b0;
        name_num = 5'd0;
        if (b0 == "x") begin
            if (name_length == 3'd2 && b1_digit) begin
                name_hit = 1'b1;
                name_num = {1'b0, d1};
            end else if (name_length == 3'd3 && b1 >= "1" && b1 <= "3" && b2_digit
                         && x_val <= 6'd31) begin
                name_hit = 1'b1;
                name_num = x_val[4:0];
            end
        end else if (name_length == 3'd2) begin
            unique case (b0)
                "t": begin
                    if (b1 >= "0" && b1 <= "2") begin
                        name_hit = 1'b1;
                        name_num = 5'(5 + d1);
                    end else if (b1 >= "3" && b1 <= "6") begin
                        name_hit = 1'b1;
                        name_num = 5'(25 + d1);
                    end else if (b1 == "p") begin
                        name_hit = 1'b1;
                        name_num = 5'd4;
                    end
                end
                "s": begin
                    if (b1 == "0" || b1 == "1") begin
                        name_hit = 1'b1;
                        name_num = 5'(8 + d1);
                    end else if (b1_digit) begin
                        name_hit = 1'b1;
                        name_num = 5'(16 + d1);
                    end else if (b1 == "p") begin
                        name_hit = 1'b1;
                        name_num = 5'd2;
                    end
                end
                "a": begin
                    if (b1 >= "0" && b1 <= "7") begin
                        name_hit = 1'b1;
                        name_num = 5'(10 + d1);
                    end
                end
                default: begin
                    unique case ({b0, b1})
                        "ra": begin name_hit = 1'b1; name_num = 5'd1; end
                        "gp": begin name_hit = 1'b1; name_num = 5'd3; end
                        "fp": begin name_hit = 1'b1; name_num = 5'd8; end
                        default: ;
                    endcase
                end
            endcase
        end else if (name_length == 3'd3) begin
            if (b0 == "s" && b1 == "1" && (b2 == "0" || b2 == "1")) begin
                name_hit = 1'b1;
                name_num = 5'(26 + b2[0]);
            end
        end else if (name_length == NAME_MAX) begin
            if ({b0, b1, b2, b3} == "zero") begin
                name_hit = 1'b1;
                name_num = 5'd0;
            end
        end
    end

endmodule

### rtl/core/rotp_parse_step.sv
// ----------------------------------------------------------------------------
// Operand parse step
// Line state registers and the one-character update, with result forming.
// ----------------------------------------------------------------------------
`include "riscv_operand_text_parser_core_defines.svh"

module rotp_parse_step
    import rotp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  rotp_item_t   item,
    output rotp_result_t result
);

    logic        line_active_reg, line_active_next;
    logic [2:0]  line_format_reg, line_format_next;
    logic [1:0]  parse_phase_reg, parse_phase_next;
    logic [31:0] name_chars_reg, name_chars_next;
    logic [2:0]  name_length_reg, name_length_next;
    logic [4:0]  reg_first_reg, reg_first_next;
    logic [4:0]  reg_second_reg, reg_second_next;
    logic [4:0]  reg_third_reg, reg_third_next;
    logic [15:0] imm_accum_reg, imm_accum_next;
    logic        imm_negative_reg, imm_negative_next;
    imm_stage_t  imm_stage_reg, imm_stage_next;
    logic        imm_skipped_reg, imm_skipped_next;
    logic        error_seen_reg, error_seen_next;
    logic        operands_done_reg, operands_done_next;

    logic [2:0]  fmt_w;
    logic        err_w, done_w, live_w, imm_ph0, term, is_digit;
    logic [31:0] name_ext;
    logic [2:0]  len_ext;
    logic        name_hit;
    logic [4:0]  name_num;
    logic [1:0]  phase_w;
    logic [31:0] name_w;
    logic [2:0]  len_w;
    logic [4:0]  r1_w, r2_w, r3_w;
    logic [15:0] acc_w, imm_val;
    logic        neg_w, skip_w;
    imm_stage_t  stage_w;
    logic [2:0]  op_count;

    function automatic logic phase_is_imm(input logic [2:0] fmt, input logic [1:0] phase);
        logic r;
        r = 1'b0;
        if (fmt == FMT_I || fmt == FMT_B)
            r = (phase == 2'd2);
        else if (fmt == FMT_S || fmt == FMT_U || fmt == FMT_J)
            r = (phase == 2'd1);
        return r;
    endfunction

    assign fmt_w = line_active_reg ? line_format_reg : item.operand_format;
    assign op_count = (fmt_w == FMT_U || fmt_w == FMT_J) ? 3'd2 : 3'd3;
    assign term = (item.char_in == CH_COMMA) || (item.char_in == CH_LPAREN)
               || (item.char_in == CH_RPAREN) || (item.char_in == CH_SPACE);
    assign is_digit = (item.char_in >= CH_ZERO) && (item.char_in <= CH_NINE);
    assign imm_ph0 = phase_is_imm(fmt_w, parse_phase_reg);
    assign live_w = !(error_seen_reg || (!line_active_reg && item.operand_format > FMT_J))
                 && !operands_done_reg;

    // Name buffer after taking this character
    always_comb begin
        name_ext = name_chars_reg;
        len_ext = name_length_reg;
        if (live_w && !imm_ph0 && !term && name_length_reg < NAME_SAT) begin
            if (name_length_reg < NAME_MAX)
                name_ext[8*name_length_reg[1:0] +: 8] = item.char_in;
            len_ext = name_length_reg + 3'd1;
        end
    end

    rotp_reg_decode u_decode (
        .name_chars  (name_ext),
        .name_length (len_ext),
        .name_hit    (name_hit),
        .name_num    (name_num)
    );

    always_comb begin
        err_w = error_seen_reg || (!line_active_reg && item.operand_format > FMT_J);
        done_w = operands_done_reg;
        phase_w = parse_phase_reg;
        name_w = name_ext;
        len_w = len_ext;
        r1_w = reg_first_reg;
        r2_w = reg_second_reg;
        r3_w = reg_third_reg;
        acc_w = imm_accum_reg;
        neg_w = imm_negative_reg;
        stage_w = imm_stage_reg;
        skip_w = imm_skipped_reg;

        if (live_w) begin
            if (imm_ph0) begin
                if (is_digit) begin
                    acc_w = {imm_accum_reg[12:0], 3'b000} + {imm_accum_reg[14:0], 1'b0}
                          + {12'd0, item.char_in[3:0]};
                    stage_w = IMM_DIGITS;
                end else if (imm_stage_reg == IMM_START && item.char_in == CH_SPACE) begin
                    skip_w = 1'b1;
                end else if (imm_stage_reg == IMM_START
                             && (item.char_in == CH_PLUS || item.char_in == CH_MINUS)) begin
                    neg_w = (item.char_in == CH_MINUS);
                    stage_w = IMM_SIGNED;
                    skip_w = 1'b1;
                end else begin
                    if (imm_stage_reg != IMM_DIGITS) begin
                        acc_w = 16'd0;
                        neg_w = 1'b0;
                    end
                    if (fmt_w == FMT_S) begin
                        if (item.char_in == CH_LPAREN
                            && (imm_stage_reg == IMM_DIGITS || !imm_skipped_reg))
                            phase_w = 2'd2;
                        else
                            err_w = 1'b1;
                    end else begin
                        done_w = 1'b1;
                    end
                end
            end else if (term && !(name_length_reg == 3'd0 && item.char_in == CH_SPACE)) begin
                name_w = 32'd0;
                len_w = 3'd0;
                if (!name_hit) begin
                    err_w = 1'b1;
                end else begin
                    unique case (parse_phase_reg)
                        2'd0: r1_w = name_num;
                        2'd1: r2_w = name_num;
                        default: r3_w = name_num;
                    endcase
                    if (fmt_w == FMT_S && parse_phase_reg == 2'd2) begin
                        if (item.char_in == CH_RPAREN)
                            done_w = 1'b1;
                        else
                            err_w = 1'b1;
                    end else if ({1'b0, parse_phase_reg} + 3'd1 == op_count) begin
                        done_w = 1'b1;
                    end else if (item.char_in == CH_COMMA) begin
                        phase_w = parse_phase_reg + 2'd1;
                    end else begin
                        err_w = 1'b1;
                    end
                end
            end
        end

        // Line end: close the open operand
        if (item.last_char && !err_w && !done_w) begin
            if (phase_is_imm(fmt_w, phase_w)) begin
                if (fmt_w == FMT_S) begin
                    err_w = 1'b1;
                end else begin
                    if (stage_w != IMM_DIGITS) begin
                        acc_w = 16'd0;
                        neg_w = 1'b0;
                    end
                    done_w = 1'b1;
                end
            end else if (fmt_w != FMT_S && {1'b0, phase_w} + 3'd1 == op_count) begin
                // a name stored this step leaves the buffer empty
                if (!name_hit || len_w == 3'd0) begin
                    err_w = 1'b1;
                end else begin
                    unique case (phase_w)
                        2'd0: r1_w = name_num;
                        2'd1: r2_w = name_num;
                        default: r3_w = name_num;
                    endcase
                    done_w = 1'b1;
                end
            end else begin
                err_w = 1'b1;
            end
        end

        imm_val = neg_w ? 16'(16'd0 - acc_w) : acc_w;
        result = '0;
        result.parse_error = err_w;
        if (!err_w) begin
            unique case (fmt_w)
                FMT_R: begin
                    result.dest_reg = r1_w;
                    result.src1_reg = r2_w;
                    result.src2_reg = r3_w;
                end
                FMT_I: begin
                    result.dest_reg = r1_w;
                    result.src1_reg = r2_w;
                    result.immediate = imm_val;
                end
                FMT_S: begin
                    result.src1_reg = r1_w;
                    result.src2_reg = r3_w;
                    result.immediate = imm_val;
                end
                FMT_B: begin
                    result.src1_reg = r1_w;
                    result.src2_reg = r2_w;
                    result.immediate = imm_val;
                end
                default: begin
                    result.dest_reg = r1_w;
                    result.immediate = imm_val;
                end
            endcase
        end

        if (item.last_char) begin
            line_active_next = 1'b0;
            line_format_next = 3'd0;
            parse_phase_next = 2'd0;
            name_chars_next = 32'd0;
            name_length_next = 3'd0;
            reg_first_next = 5'd0;
            reg_second_next = 5'd0;
            reg_third_next = 5'd0;
            imm_accum_next = 16'd0;
            imm_negative_next = 1'b0;
            imm_stage_next = IMM_START;
            imm_skipped_next = 1'b0;
            error_seen_next = 1'b0;
            operands_done_next = 1'b0;
        end else begin
            line_active_next = 1'b1;
            line_format_next = fmt_w;
            parse_phase_next = phase_w;
            name_chars_next = name_w;
            name_length_next = len_w;
            reg_first_next = r1_w;
            reg_second_next = r2_w;
            reg_third_next = r3_w;
            imm_accum_next = acc_w;
            imm_negative_next = neg_w;
            imm_stage_next = stage_w;
            imm_skipped_next = skip_w;
            error_seen_next = err_w;
            operands_done_next = done_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            line_format_reg <= 3'd0;
            parse_phase_reg <= 2'd0;
            name_chars_reg <= 32'd0;
            name_length_reg <= 3'd0;
            reg_first_reg <= 5'd0;
            reg_second_reg <= 5'd0;
            reg_third_reg <= 5'd0;
            imm_accum_reg <= 16'd0;
            imm_negative_reg <= 1'b0;
            imm_stage_reg <= IMM_START;
            imm_skipped_reg <= 1'b0;
            error_seen_reg <= 1'b0;
            operands_done_reg <= 1'b0;
        end else if (step_en) begin
            line_active_reg <= line_active_next;
            line_format_reg <= line_format_next;
            parse_phase_reg <= parse_phase_next;
            name_chars_reg <= name_chars_next;
            name_length_reg <= name_length_next;
            reg_first_reg <= reg_first_next;
            reg_second_reg <= reg_second_next;
            reg_third_reg <= reg_third_next;
            imm_accum_reg <= imm_accum_next;
            imm_negative_reg <= imm_negative_next;
            imm_stage_reg <= imm_stage_next;
            imm_skipped_reg <= imm_skipped_next;
            error_seen_reg <= error_seen_next;
            operands_done_reg <= operands_done_next;
        end
    end

    `ROTP_ASSERT_NEXT(a_line_cleared, aclk, aresetn, step_en && item.last_char, !line_active_reg && !error_seen_reg && name_length_reg == 3'd0, "line state not cleared after line end")
    `ROTP_ASSERT_IMPL(a_idle_no_error, aclk, aresetn, !line_active_reg, !error_seen_reg && !operands_done_reg, "status set outside a line")
    `ROTP_ASSERT_IMPL(a_name_len_sat, aclk, aresetn, 1'b1, name_length_reg <= NAME_SAT, "name length beyond saturation")

endmodule

### rtl/core/riscv_operand_text_parser_core.sv
// Operand text parser: takes one character transaction per clock on the s_ side, with the
// format code in s_tuser and s_tlast marking the line end, and gives one result transaction
// per line on the m_ side. A character is held in an input register and folded into the line
// state by a combinational update (name decode, decimal accumulate) when it advances; the line
// result is registered, so it appears once the last character of the line has advanced.
// Throughput is one character per cycle; s_tready falls only while a line-end character waits
// for the result register, which is still occupied by an untaken result.
// ----------------------------------------------------------------------------
// Operand text parser top level
// Input register, parse step and result register with stream handshakes.
// ----------------------------------------------------------------------------
`include "riscv_operand_text_parser_core_defines.svh"

module riscv_operand_text_parser_core
    import rotp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [2:0]  s_tuser,   // [2:0] operand_format
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] dest_reg, [9:5] src1_reg, [14:10] src2_reg,
                                   // [30:15] immediate, [31] zero
    output logic [0:0]  m_tuser    // [0] parse_error
);

    logic         in_valid_reg, in_valid_next;
    rotp_item_t   in_item_reg;
    logic         out_valid_reg, out_valid_next;
    rotp_result_t out_data_reg;
    rotp_result_t step_result;
    logic         advance;

    assign advance = in_valid_reg && (!in_item_reg.last_char || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = (advance && in_item_reg.last_char) || (out_valid_reg && !m_tready);

    rotp_parse_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.char_in <= s_tdata;
            in_item_reg.operand_format <= s_tuser;
            in_item_reg.last_char <= s_tlast;
        end
        if (advance && in_item_reg.last_char) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, out_data_reg.immediate, out_data_reg.src2_reg,
                      out_data_reg.src1_reg, out_data_reg.dest_reg};
    assign m_tuser = out_data_reg.parse_error;

    `ROTP_ASSERT_IMPL(a_error_fields_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 32'd0, "error result with nonzero fields")
    `ROTP_ASSERT_NEXT(a_line_end_result, aclk, aresetn, advance && in_item_reg.last_char, m_tvalid, "line end produced no result")
    `ROTP_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, in_valid_reg && in_item_reg.last_char && out_valid_reg && !m_tready, "input stalled without a full result register")

endmodule

### test/riscv_operand_text_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand text parser testbench
// Feeds operand text one character per transaction, directed lines first and
// then random lines (well-formed, broken and noise), while both stream sides
// stall at random. A scoreboard predicts each line result and checks it.
// ----------------------------------------------------------------------------
module riscv_operand_text_parser_core_tb
    import rotp_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PRINT_LIMIT    = 50;

    // Tracks one line of operand text and queues the result it should give
    class operand_parse_scoreboard;
        bit           line_active;
        logic [2:0]   line_fmt;
        logic [2:0]   phase;
        logic [31:0]  name_buf;
        logic [2:0]   name_len;
        logic [4:0]   reg_a, reg_b, reg_c;
        logic [15:0]  imm_acc;
        bit           imm_neg;
        imm_stage_t   imm_stage;
        bit           imm_skipped;
        bit           err;
        bit           done;
        rotp_result_t pending_results[$];
        int           errors;
        int           lines_checked;
        int           error_lines;

        function new();
            clear_line();
        endfunction

        function void clear_line();
            line_active = 0;
            line_fmt    = FMT_R;
            phase       = '0;
            name_buf    = '0;
            name_len    = '0;
            reg_a       = '0;
            reg_b       = '0;
            reg_c       = '0;
            imm_acc     = '0;
            imm_neg     = 0;
            imm_stage   = IMM_START;
            imm_skipped = 0;
            err         = 0;
            done        = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit is_digit(byte unsigned ch);
            return ch >= CH_ZERO && ch <= CH_NINE;
        endfunction

        function int operand_total(logic [2:0] fmt);
            return (fmt == FMT_U || fmt == FMT_J) ? 2 : 3;
        endfunction

        function bit in_imm();
            case (line_fmt)
                FMT_I, FMT_B:        return phase == 2;
                FMT_S, FMT_U, FMT_J: return phase == 1;
                default:             return 0;
            endcase
        endfunction

        // -1 for anything that is not a whole register name
        function int decode_reg_name();
            logic [31:0]  word;
            byte unsigned ch;
            byte unsigned d1;
            byte unsigned d2;
            int           v;
            word = '0;
            if (name_len == 0 || name_len > NAME_MAX)
                return -1;
            for (int k = 0; k < name_len; k++) begin
                ch = name_buf[8*k +: 8];
                if (ch == 8'h00)
                    return -1;
                word = {word[23:0], ch};
            end
            d1 = name_buf[15:8];
            d2 = name_buf[23:16];
            if (name_buf[7:0] == "x") begin
                if (name_len == 2 && is_digit(d1))
                    return d1 - CH_ZERO;
                if (name_len == 3 && d1 >= "1" && d1 <= "3" && is_digit(d2)) begin
                    v = (d1 - CH_ZERO) * 10 + (d2 - CH_ZERO);
                    return (v <= 31) ? v : -1;
                end
                return -1;
            end
            case (word)
                "zero": return 0;
                "ra":   return 1;
                "sp":   return 2;
                "gp":   return 3;
                "tp":   return 4;
                "t0":   return 5;
                "t1":   return 6;
                "t2":   return 7;
                "s0":   return 8;
                "fp":   return 8;
                "s1":   return 9;
                "a0":   return 10;
                "a1":   return 11;
                "a2":   return 12;
                "a3":   return 13;
                "a4":   return 14;
                "a5":   return 15;
                "a6":   return 16;
                "a7":   return 17;
                "s2":   return 18;
                "s3":   return 19;
                "s4":   return 20;
                "s5":   return 21;
                "s6":   return 22;
                "s7":   return 23;
                "s8":   return 24;
                "s9":   return 25;
                "s10":  return 26;
                "s11":  return 27;
                "t3":   return 28;
                "t4":   return 29;
                "t5":   return 30;
                "t6":   return 31;
                default: return -1;
            endcase
        endfunction

        function bit latch_reg();
            int r;
            r = decode_reg_name();
            name_buf = '0;
            name_len = '0;
            if (r < 0) begin
                err = 1;
                return 0;
            end
            case (phase)
                3'd0:    reg_a = r[4:0];
                3'd1:    reg_b = r[4:0];
                default: reg_c = r[4:0];
            endcase
            return 1;
        endfunction

        function void absorb_imm_char(byte unsigned ch);
            bit converted;
            if (is_digit(ch)) begin
                imm_acc   = imm_acc * 10 + (ch - CH_ZERO);
                imm_stage = IMM_DIGITS;
                return;
            end
            if (imm_stage == IMM_START && ch == CH_SPACE) begin
                imm_skipped = 1;
                return;
            end
            if (imm_stage == IMM_START && (ch == CH_PLUS || ch == CH_MINUS)) begin
                imm_neg     = (ch == CH_MINUS);
                imm_stage   = IMM_SIGNED;
                imm_skipped = 1;
                return;
            end
            converted = (imm_stage == IMM_DIGITS);
            if (!converted) begin
                imm_acc = '0;
                imm_neg = 0;
            end
            // S needs '(' after the offset; a bare sign or spaces without digits is bad
            if (line_fmt == FMT_S) begin
                if (ch == CH_LPAREN && (converted || !imm_skipped))
                    phase = 3'd2;
                else
                    err = 1;
            end else begin
                done = 1;
            end
        endfunction

        function void absorb_char(byte unsigned ch);
            bit term;
            if (in_imm()) begin
                absorb_imm_char(ch);
                return;
            end
            term = ch == CH_COMMA || ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_SPACE;
            if (!term) begin
                if (name_len < NAME_SAT) begin
                    if (name_len < NAME_MAX)
                        name_buf[8*name_len +: 8] = ch;
                    name_len++;
                end
                return;
            end
            if (name_len == 0 && ch == CH_SPACE)
                return;
            if (!latch_reg())
                return;
            if (line_fmt == FMT_S && phase == 2) begin
                if (ch == CH_RPAREN)
                    done = 1;
                else
                    err = 1;
            end else if (phase + 1 == operand_total(line_fmt)) begin
                done = 1;
            end else if (ch == CH_COMMA) begin
                phase++;
            end else begin
                err = 1;
            end
        endfunction

        function void close_line();
            if (in_imm()) begin
                if (line_fmt == FMT_S) begin
                    err = 1;
                end else begin
                    if (imm_stage != IMM_DIGITS) begin
                        imm_acc = '0;
                        imm_neg = 0;
                    end
                    done = 1;
                end
            end else if (line_fmt != FMT_S && phase + 1 == operand_total(line_fmt)) begin
                if (latch_reg())
                    done = 1;
            end else begin
                err = 1;
            end
        endfunction

        // Called for every accepted character transaction
        function void note_char(byte unsigned ch, logic [2:0] fmt, bit last);
            rotp_result_t res;
            logic [15:0]  imm;
            if (!line_active) begin
                line_active = 1;
                line_fmt    = fmt;
                if (fmt > FMT_J)
                    err = 1;
            end
            if (!err && !done)
                absorb_char(ch);
            if (!last)
                return;
            if (!err && !done)
                close_line();
            res = '0;
            if (err) begin
                res.parse_error = 1'b1;
                error_lines++;
            end else begin
                imm = imm_neg ? -imm_acc : imm_acc;
                case (line_fmt)
                    FMT_R: begin
                        res.dest_reg = reg_a;
                        res.src1_reg = reg_b;
                        res.src2_reg = reg_c;
                    end
                    FMT_I: begin
                        res.dest_reg  = reg_a;
                        res.src1_reg  = reg_b;
                        res.immediate = imm;
                    end
                    FMT_S: begin
                        res.src1_reg  = reg_a;
                        res.src2_reg  = reg_c;
                        res.immediate = imm;
                    end
                    FMT_B: begin
                        res.src1_reg  = reg_a;
                        res.src2_reg  = reg_b;
                        res.immediate = imm;
                    end
                    default: begin
                        res.dest_reg  = reg_a;
                        res.immediate = imm;
                    end
                endcase
            end
            pending_results.push_back(res);
            clear_line();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("[%0t] MISMATCH line %0d: %s", $realtime, lines_checked, msg);
            errors++;
        endtask

        task check_result(logic [31:0] data, logic perr);
            rotp_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected, tdata=%h tuser=%b",
                                 data, perr));
                return;
            end
            want = pending_results.pop_front();
            lines_checked++;
            if (data[4:0] !== want.dest_reg)
                report($sformatf("dest_reg %0d, want %0d", data[4:0], want.dest_reg));
            if (data[9:5] !== want.src1_reg)
                report($sformatf("src1_reg %0d, want %0d", data[9:5], want.src1_reg));
            if (data[14:10] !== want.src2_reg)
                report($sformatf("src2_reg %0d, want %0d", data[14:10], want.src2_reg));
            if (data[30:15] !== want.immediate)
                report($sformatf("immediate %h, want %h", data[30:15], want.immediate));
            if (data[31] !== 1'b0)
                report("tdata pad bit set");
            if (perr !== want.parse_error)
                report($sformatf("parse_error %b, want %b", perr, want.parse_error));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    operand_parse_scoreboard sb = new();

    byte unsigned line_buf[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;
    int           chars_sent;
    int           lines_sent;
    int           quiet_cycles;

    string alias_names[] = '{"zero", "ra", "sp", "gp", "tp", "t0", "t1", "t2", "t3", "t4",
                             "t5", "t6", "s0", "fp", "s1", "s2", "s3", "s4", "s5", "s6",
                             "s7", "s8", "s9", "s10", "s11", "a0", "a1", "a2", "a3", "a4",
                             "a5", "a6", "a7"};
    string bad_names[]   = '{"pc", "x32", "x01", "s12", "a8", "t7", "zeros", "x", "xx1",
                             "fpp", "x3a"};

    riscv_operand_text_parser_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: random stalls, plus a long hold-off when requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Inputs change only at rising edges, so the negedge sees what the next edge takes
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_char(input byte unsigned ch, input logic [2:0] fmt, input bit last);
        bit ok;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= fmt;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        sb.note_char(ch, fmt, last);
        chars_sent++;
    endtask

    // Format is only sampled on the first character; later ones carry junk in tuser
    task automatic send_line(input logic [2:0] fmt);
        for (int k = 0; k < line_buf.size(); k++)
            send_char(line_buf[k], (k == 0) ? fmt : 3'($urandom_range(7)),
                      k == line_buf.size() - 1);
        lines_sent++;
    endtask

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endfunction

    task automatic send_text(input string s, input logic [2:0] fmt);
        line_buf.delete();
        add_text(s);
        send_line(fmt);
    endtask

    function automatic void add_spaces(input int maxn);
        int n;
        n = ($urandom_range(9) < 3) ? $urandom_range(1, maxn) : 0;
        repeat (n) line_buf.push_back(CH_SPACE);
    endfunction

    function automatic string random_reg_name();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return bad_names[$urandom_range(bad_names.size() - 1)];
        if (pick < 50)
            return $sformatf("x%0d", $urandom_range(31));
        return alias_names[$urandom_range(alias_names.size() - 1)];
    endfunction

    // Up to six digits so the 16-bit wrap is hit regularly
    function automatic void add_imm();
        int ndig;
        add_spaces(1);
        case ($urandom_range(7))
            0: line_buf.push_back(CH_MINUS);
            1: line_buf.push_back(CH_PLUS);
            2: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        ndig = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        repeat (ndig) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    function automatic void build_random_line(output logic [2:0] fmt);
        int roll;
        int n;
        int pos;
        line_buf.delete();
        roll = $urandom_range(99);
        if (roll < 8) begin
            fmt = 3'($urandom_range(7));
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
            return;
        end
        fmt = (roll < 12) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
        add_spaces(2);
        add_text(random_reg_name());
        line_buf.push_back(CH_COMMA);
        case (fmt)
            FMT_R: begin
                add_spaces(2);
                add_text(random_reg_name());
                line_buf.push_back(CH_COMMA);
                add_spaces(2);
                add_text(random_reg_name());
            end
            FMT_I, FMT_B: begin
                add_spaces(2);
                add_text(random_reg_name());
                line_buf.push_back(CH_COMMA);
                add_imm();
            end
            FMT_S: begin
                add_imm();
                line_buf.push_back(CH_LPAREN);
                add_spaces(1);
                add_text(random_reg_name());
                line_buf.push_back(CH_RPAREN);
            end
            default: add_imm();
        endcase
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, 4);
            repeat (n) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        // Occasional damage: corrupt a character, cut the line short, or slip in a space
        roll = $urandom_range(99);
        if (roll < 10) begin
            pos = $urandom_range(line_buf.size() - 1);
            line_buf[pos] = 8'($urandom_range(255));
        end else if (roll < 16) begin
            n = $urandom_range(1, line_buf.size());
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end else if (roll < 20) begin
            pos = $urandom_range(line_buf.size());
            line_buf.insert(pos, CH_SPACE);
        end
    endfunction

    task automatic send_random_until(input int char_goal);
        logic [2:0] fmt;
        while (chars_sent < char_goal) begin
            build_random_line(fmt);
            send_line(fmt);
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        s_tlast       <= 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 59;
        hold_cycles   = 0;
        chars_sent    = 0;
        lines_sent    = 0;
        quiet_cycles  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("x0,x31,t2", FMT_R);
        send_text("ra, sp, -32768", FMT_I);
        send_text("s11, 12(s10)", FMT_S);
        send_text("a0,(fp)", FMT_S);           // no offset digits: zero
        send_text("a0, -(fp)", FMT_S);         // sign with no digits
        send_text("zero,t6,+65535", FMT_B);    // wraps
        send_text("gp,99999 x", FMT_U);        // text after immediate ignored
        send_text("tp,", FMT_J);               // empty trailing immediate
        send_text("x1,x2,x3", 3'd6);
        send_text("a1,9", 3'd7);
        send_text("pc,x1,x2", FMT_R);
        send_text("x1 ,x2,x3", FMT_R);         // space before comma
        send_text("x1,x2", FMT_R);             // short line
        send_text("x1,x2,x3)z", FMT_R);
        send_text("s1,x32,5", FMT_I);
        send_text("zeros,1", FMT_U);
        send_text("s1,4(a7", FMT_S);
        send_text("a2,a3,7(", FMT_I);
        send_text("t0,  - 42", FMT_J);
        send_text("x", FMT_R);

        send_random_until(700);
        send_idle_pct = 59;
        recv_idle_pct = 26;
        send_random_until(1400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        send_random_until(2100);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d lines in %0d characters over all formats, bad codes and noise;",
                 lines_sent, chars_sent);
        $display("checked %0d results, %0d of them flagged as parse errors.",
                 sb.lines_checked, sb.error_lines);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rotp_pkg.sv
rtl/core/rotp_reg_decode.sv
rtl/core/rotp_parse_step.sv
rtl/core/riscv_operand_text_parser_core.sv
test/riscv_operand_text_parser_core_tb.sv
